[rtl/core/ssr_pkg.sv]
`default_nettype none

package ssr_pkg;

  // Shape selector; code three folds onto the parallelogram.
  typedef enum logic [1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_PARA   = 2'd2
  } shape_t;

  // Register map: index is the word address.
  localparam int IW = 3;
  localparam int AW = IW + 2;
  localparam logic [IW-1:0] REG_MODE   = 3'd0;
  localparam logic [IW-1:0] REG_RADIUS = 3'd1;
  localparam logic [IW-1:0] REG_AX     = 3'd2;
  localparam logic [IW-1:0] REG_AY     = 3'd3;
  localparam logic [IW-1:0] REG_BX     = 3'd4;
  localparam logic [IW-1:0] REG_BY     = 3'd5;

  localparam int DW  = 32;  // bus data width
  localparam int VW  = 9;   // vector component width
  localparam int RW  = 8;   // radius width
  localparam int OW  = 9;   // output coordinate width
  localparam int CW  = 11;  // signed scan coordinate width
  localparam int OPW = 12;  // edge-function operand width
  localparam int PW  = 2 * OPW;
  localparam int EW  = PW + 1;
  localparam int NE  = 6;   // edge-function units

  typedef struct packed {
    shape_t                shape;
    logic signed [CW-1:0]  row;
    logic signed [CW-1:0]  col;
    logic        [RW-1:0]  r;
    logic signed [VW-1:0]  ax;
    logic signed [VW-1:0]  ay;
    logic signed [VW-1:0]  bx;
    logic signed [VW-1:0]  by;
  } cover_in_t;

  function automatic logic same3(input logic a, input logic b, input logic c);
    return (a == b) && (b == c);
  endfunction

endpackage

`default_nettype wire

[rtl/core/shape_scan_rasterizer_unit.sv]
// Pipeline: an accepted input beat goes through stage 1 (edge products), then the output register (decision).
// Throughput: one pixel per cycle unless out_ready stalls the pipeline; each input beat yields
//   exactly one result beat, and the scan counters advance in the cycle the beat is accepted.
// Reset (rst_n low, synchronous): registers read 0, no frame running, pipeline empty;
//   the first input beat after reset starts a new frame.
`default_nettype none

module shape_scan_rasterizer_unit #(
  parameter int COORD_MAX = 255
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ssr_pkg::AW-1:0] paddr,
  input  wire logic [ssr_pkg::DW-1:0] pwdata,
  output logic      [ssr_pkg::DW-1:0] prdata,
  output logic                        pready,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_restart,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_inside_res,
  output logic      [ssr_pkg::OW-1:0] out_row_coord,
  output logic      [ssr_pkg::OW-1:0] out_col_coord,
  output logic                        out_row_end,
  output logic                        out_frame_end,
  output logic                        out_frame_empty
);
  import ssr_pkg::*;

  // Largest usable vector magnitude / radius.
  localparam int VMAX = (COORD_MAX < 255) ? COORD_MAX : 255;
  localparam logic signed [VW-1:0] VLIM = VW'(VMAX);
  localparam logic        [RW-1:0] RLIM = RW'(VMAX);
  // A 9-bit component reaches -256; clamp only when that lies past the limit.
  localparam bit VCLAMP = (COORD_MAX < 256);

  function automatic logic signed [VW-1:0] sat_vec(input logic [VW-1:0] v);
    logic signed [VW-1:0] s;
    s = $signed(v);
    if (!VCLAMP)        return s;
    else if (s > VLIM)  return VLIM;
    else if (s < -VLIM) return -VLIM;
    else                return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Keep the raw value for readback and a saturated
  // copy, formed at write time, for the scan logic.
  // ---------------------------------------------------------------------------
  logic                 cfg_wr;
  logic [IW-1:0]        cfg_idx;
  logic [1:0]           cfg_mode_r;
  logic [RW-1:0]        cfg_radius_r, cfg_rad_sat_r;
  logic [VW-1:0]        cfg_ax_r, cfg_ay_r, cfg_bx_r, cfg_by_r;
  logic signed [VW-1:0] cfg_ax_sat_r, cfg_ay_sat_r, cfg_bx_sat_r, cfg_by_sat_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r    <= '0;
      cfg_radius_r  <= '0;
      cfg_rad_sat_r <= '0;
      cfg_ax_r      <= '0;
      cfg_ay_r      <= '0;
      cfg_bx_r      <= '0;
      cfg_by_r      <= '0;
      cfg_ax_sat_r  <= '0;
      cfg_ay_sat_r  <= '0;
      cfg_bx_sat_r  <= '0;
      cfg_by_sat_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:   cfg_mode_r <= pwdata[1:0];
        REG_RADIUS: begin
          cfg_radius_r  <= pwdata[RW-1:0];
          cfg_rad_sat_r <= (pwdata[RW-1:0] > RLIM) ? RLIM : pwdata[RW-1:0];
        end
        REG_AX: begin
          cfg_ax_r     <= pwdata[VW-1:0];
          cfg_ax_sat_r <= sat_vec(pwdata[VW-1:0]);
        end
        REG_AY: begin
          cfg_ay_r     <= pwdata[VW-1:0];
          cfg_ay_sat_r <= sat_vec(pwdata[VW-1:0]);
        end
        REG_BX: begin
          cfg_bx_r     <= pwdata[VW-1:0];
          cfg_bx_sat_r <= sat_vec(pwdata[VW-1:0]);
        end
        REG_BY: begin
          cfg_by_r     <= pwdata[VW-1:0];
          cfg_by_sat_r <= sat_vec(pwdata[VW-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:   prdata = DW'(cfg_mode_r);
      REG_RADIUS: prdata = DW'(cfg_radius_r);
      REG_AX:     prdata = DW'(cfg_ax_r);
      REG_AY:     prdata = DW'(cfg_ay_r);
      REG_BX:     prdata = DW'(cfg_bx_r);
      REG_BY:     prdata = DW'(cfg_by_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds edge products, the output register holds the
  // decision. Each stage advances when the one behind it is empty or leaving.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, out_valid_r;
  logic out_adv, s1_move, in_acc;

  assign out_adv   = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Scan sequencer. A new frame latches the registers when restart is set or
  // no frame is running; otherwise the latched frame values drive the pixel.
  // ---------------------------------------------------------------------------
  shape_t               cfg_shape, f_shape_r, c_shape;
  logic [RW-1:0]        f_r_r, c_r;
  logic signed [VW-1:0] f_ax_r, f_ay_r, f_bx_r, f_by_r;
  logic signed [VW-1:0] c_ax, c_ay, c_bx, c_by;
  logic signed [CW-1:0] f_last_col_r, scan_row_r, scan_col_r;
  logic                 in_frame_r;

  logic                 start;
  logic signed [CW-1:0] st_row, st_last_col, st_two_r;
  logic signed [CW-1:0] c_row, c_col, c_last_col, c_last_row, c_two_r;
  logic                 c_empty, c_row_end, c_frame_end;
  cover_in_t            cov_in;
  logic                 cov_inside;

  always_comb begin
    if (cfg_mode_r == 2'(SHAPE_CIRCLE))   cfg_shape = SHAPE_CIRCLE;
    else if (cfg_mode_r == 2'(SHAPE_TRI)) cfg_shape = SHAPE_TRI;
    else                                  cfg_shape = SHAPE_PARA;
  end

  assign start = in_restart || !in_frame_r;

  // Frame bounds as they would be at a frame start.
  assign st_two_r = $signed(CW'({cfg_rad_sat_r, 1'b0}));
  always_comb begin
    case (cfg_shape)
      SHAPE_CIRCLE: begin
        st_row      = '0;
        st_last_col = st_two_r;
      end
      SHAPE_TRI: begin
        st_row      = CW'(cfg_ay_sat_r) - CW'(cfg_by_sat_r);
        st_last_col = (cfg_bx_sat_r > cfg_ax_sat_r) ? CW'(cfg_bx_sat_r) : CW'(cfg_ax_sat_r);
      end
      default: begin
        st_row      = CW'(cfg_ay_sat_r) - CW'(cfg_by_sat_r);
        st_last_col = CW'(cfg_ax_sat_r) + CW'(cfg_bx_sat_r);
      end
    endcase
  end

  assign c_shape    = start ? cfg_shape     : f_shape_r;
  assign c_r        = start ? cfg_rad_sat_r : f_r_r;
  assign c_ax       = start ? cfg_ax_sat_r  : f_ax_r;
  assign c_ay       = start ? cfg_ay_sat_r  : f_ay_r;
  assign c_bx       = start ? cfg_bx_sat_r  : f_bx_r;
  assign c_by       = start ? cfg_by_sat_r  : f_by_r;
  assign c_row      = start ? st_row        : scan_row_r;
  assign c_col      = start ? '0            : scan_col_r;
  assign c_last_col = start ? st_last_col   : f_last_col_r;
  assign c_two_r    = $signed(CW'({c_r, 1'b0}));
  assign c_last_row = (c_shape == SHAPE_CIRCLE) ? c_two_r : '0;

  // Empty grid: negative height or negative last column at frame start.
  assign c_empty     = start && (st_row[CW-1] || st_last_col[CW-1]);
  assign c_row_end   = !c_empty && (c_col >= c_last_col);
  assign c_frame_end = c_empty || (c_row_end && (c_row == c_last_row));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      scan_row_r   <= '0;
      scan_col_r   <= '0;
      f_shape_r    <= SHAPE_CIRCLE;
      f_r_r        <= '0;
      f_ax_r       <= '0;
      f_ay_r       <= '0;
      f_bx_r       <= '0;
      f_by_r       <= '0;
      f_last_col_r <= '0;
    end else if (in_acc) begin
      if (start) begin
        f_shape_r    <= cfg_shape;
        f_r_r        <= cfg_rad_sat_r;
        f_ax_r       <= cfg_ax_sat_r;
        f_ay_r       <= cfg_ay_sat_r;
        f_bx_r       <= cfg_bx_sat_r;
        f_by_r       <= cfg_by_sat_r;
        f_last_col_r <= st_last_col;
      end
      if (c_empty) begin
        in_frame_r <= 1'b0;
        scan_row_r <= '0;
      end else if (c_frame_end) begin
        in_frame_r <= 1'b0;
      end else begin
        in_frame_r <= 1'b1;
        if (c_row_end) begin
          // circle rows count up, polygon rows count down
          scan_col_r <= '0;
          scan_row_r <= (c_shape == SHAPE_CIRCLE) ? c_row + CW'(1) : c_row - CW'(1);
        end else begin
          scan_col_r <= c_col + CW'(1);
          scan_row_r <= c_row;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edge products (inside the coverage unit) plus sideband fields.
  // ---------------------------------------------------------------------------
  logic          s1_row_end_r, s1_frame_end_r, s1_empty_r;
  logic [OW-1:0] s1_row_r, s1_col_r;

  assign cov_in = '{shape: c_shape, row: c_row, col: c_col, r: c_r,
                    ax: c_ax, ay: c_ay, bx: c_bx, by: c_by};

  ssr_cover u_cover (
    .clk  (clk),
    .load (in_acc),
    .ci   (cov_in),
    .hit  (cov_inside)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (out_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r       <= c_empty ? '0 : c_row[OW-1:0];
      s1_col_r       <= c_empty ? '0 : c_col[OW-1:0];
      s1_row_end_r   <= c_row_end;
      s1_frame_end_r <= c_frame_end;
      s1_empty_r     <= c_empty;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while the downstream stalls.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_inside_res  <= !s1_empty_r && cov_inside;
      out_row_coord   <= s1_row_r;
      out_col_coord   <= s1_col_r;
      out_row_end     <= s1_row_end_r;
      out_frame_end   <= s1_frame_end_r;
      out_frame_empty <= s1_empty_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_empty |-> out_frame_end && !out_inside_res && !out_row_end)
    else $error("empty-frame beat carries pixel fields");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end && !out_frame_empty |-> out_row_end)
    else $error("frame end without row end");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted beat lost before stage 1");

  a_empty_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && c_empty |=> !in_frame_r)
    else $error("frame still running after empty grid");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |-> !in_ready)
    else $error("input taken while both stages are full");

endmodule

`default_nettype wire

[rtl/core/ssr_cover.sv]
`default_nettype none

module ssr_cover (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire ssr_pkg::cover_in_t ci,
  output logic                    hit
);
  import ssr_pkg::*;

  logic signed [OPW-1:0] op_p [NE];
  logic signed [OPW-1:0] op_q [NE];
  logic signed [OPW-1:0] op_s [NE];
  logic signed [OPW-1:0] op_t [NE];
  logic signed [OPW-1:0] ix, jx, rx, axx, ayx, bxx, byx;

  logic signed [PW-1:0]  pa_r [NE];
  logic signed [PW-1:0]  pb_r [NE];
  shape_t                shape_r;

  logic signed [EW-1:0]  edge_v [NE];
  logic                  le [NE];
  logic signed [EW-1:0]  circ_sum;

  assign ix  = OPW'(ci.row);
  assign jx  = OPW'(ci.col);
  assign rx  = $signed(OPW'(ci.r));
  assign axx = OPW'(ci.ax);
  assign ayx = OPW'(ci.ay);
  assign bxx = OPW'(ci.bx);
  assign byx = OPW'(ci.by);

  // Each unit forms p*q - s*t.
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      op_p[k] = '0;
      op_q[k] = '0;
      op_s[k] = '0;
      op_t[k] = '0;
    end
    case (ci.shape)
      SHAPE_CIRCLE: begin
        op_p[0] = rx - jx;  op_q[0] = rx - jx;  op_s[0] = rx;  op_t[0] = rx;
        op_p[1] = rx - ix;  op_q[1] = rx - ix;
      end
      SHAPE_TRI: begin
        op_p[0] = axx;       op_q[0] = ix - ayx + byx;
        op_s[0] = ayx;       op_t[0] = jx - axx;
        op_p[1] = jx - bxx;  op_q[1] = ayx - byx;
        op_s[1] = axx - bxx; op_t[1] = ix;
        op_p[2] = jx;        op_q[2] = byx;
        op_s[2] = bxx;       op_t[2] = ix + byx;
      end
      default: begin
        // upper triangle: units 0, 4, 5; lower triangle: units 3, 1, 2
        op_p[0] = axx;            op_q[0] = ix - ayx + byx;
        op_s[0] = ayx;            op_t[0] = jx - axx;
        op_p[1] = ayx;            op_q[1] = jx - bxx;
        op_s[1] = ix;             op_t[1] = axx;
        op_p[2] = jx;             op_q[2] = byx;
        op_s[2] = bxx;            op_t[2] = ix + byx;
        op_p[3] = -(ayx + byx);   op_q[3] = jx - axx - bxx;
        op_s[3] = ix - ayx;       op_t[3] = -(axx + bxx);
        op_p[4] = bxx;            op_q[4] = ix - ayx;
        op_s[4] = byx;            op_t[4] = jx - axx - bxx;
        op_p[5] = ayx + byx;      op_q[5] = jx;
        op_s[5] = ix + byx;       op_t[5] = axx + bxx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shape_r <= ci.shape;
      for (int k = 0; k < NE; k++) begin
        pa_r[k] <= PW'(op_p[k]) * PW'(op_q[k]);
        pb_r[k] <= PW'(op_s[k]) * PW'(op_t[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      edge_v[k] = EW'(pa_r[k]) - EW'(pb_r[k]);
      le[k]     = edge_v[k][EW-1] || (edge_v[k] == '0);
    end
  end

  assign circ_sum = edge_v[0] + edge_v[1];

  always_comb begin
    case (shape_r)
      SHAPE_CIRCLE: hit = circ_sum[EW-1] || (circ_sum == '0);
      SHAPE_TRI:    hit = same3(le[0], le[1], le[2]);
      default:      hit = same3(le[3], le[1], le[2]) || same3(le[0], le[4], le[5]);
    endcase
  end

endmodule

`default_nettype wire
